/* rtl/core/dpe_pkg.sv */
`default_nettype none

package dpe_pkg;

    // Field widths of the request and result words.
    localparam int PRICE_WIDTH  = 14;
    localparam int VOLUME_WIDTH = 20;
    localparam int TOTAL_WIDTH  = 34;
    localparam int CODE_WIDTH   = 4;
    localparam int BYTE_WIDTH   = 8;

    // Packet layout.
    localparam int PACKET_LEN = 16;
    localparam int IDX_WIDTH  = $clog2(PACKET_LEN);

    // Binary to BCD conversion: each cell holds one decimal digit and the
    // row shifts BITS_PER_STEP binary bits per clock while it steps.
    localparam int WIDE_WIDTH    = TOTAL_WIDTH;
    localparam int NUM_DIGITS    = 11;
    localparam int BITS_PER_STEP = 3;
    localparam int STEP_COUNT    = (WIDE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int BIN_WIDTH     = STEP_COUNT * BITS_PER_STEP;
    localparam int CNT_WIDTH     = $clog2(STEP_COUNT + 1);

    // First product digit of the amount (the product is divided by 1000).
    localparam int AMOUNT_SHIFT = 3;

    // Command codes.
    localparam logic CMD_SALE  = 1'b0;
    localparam logic CMD_TOTAL = 1'b1;

    // Display codes.
    localparam logic [CODE_WIDTH-1:0] ZERO_CODE  = 4'd0;
    localparam logic [CODE_WIDTH-1:0] L_CODE     = 4'd10;
    localparam logic [CODE_WIDTH-1:0] BLANK_CODE = 4'd15;

    typedef struct packed {
        logic                    command;
        logic [VOLUME_WIDTH-1:0] volume_milli;
        logic [TOTAL_WIDTH-1:0]  totalizer_milli;
    } in_word_t;

    typedef struct packed {
        logic [BYTE_WIDTH-1:0] packet_byte;
        logic                  last_of_packet;
    } out_word_t;

    // Control that the sequencer sends to every conversion row.
    typedef struct packed {
        logic load;
        logic step;
    } chain_ctrl_t;

    typedef logic [NUM_DIGITS-1:0][CODE_WIDTH-1:0] digit_vec_t;
    typedef logic [PACKET_LEN-1:0][CODE_WIDTH-1:0] code_vec_t;

    // Bit i is set when any digit at position i or above is nonzero.
    function automatic logic [NUM_DIGITS-1:0] suffix_nonzero(input digit_vec_t digits);
        logic [NUM_DIGITS-1:0] nz;
        nz[NUM_DIGITS-1] = (digits[NUM_DIGITS-1] != '0);
        for (int i = NUM_DIGITS - 2; i >= 0; i--)
        begin
            nz[i] = nz[i+1] | (digits[i] != '0);
        end
        return nz;
    endfunction

    // A digit is shown while value remains; otherwise it is blank, or 0 in
    // the lowest position of a field that shows zero.
    function automatic logic [CODE_WIDTH-1:0] disp_code(input logic [CODE_WIDTH-1:0] digit,
                                                        input logic nz,
                                                        input logic show_zero);
        logic [CODE_WIDTH-1:0] code;
        if (nz)
        begin
            code = digit;
        end
        else if (show_zero)
        begin
            code = ZERO_CODE;
        end
        else
        begin
            code = BLANK_CODE;
        end
        return code;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/dpe_digit_cell.sv */
`default_nettype none

module dpe_digit_cell
    import dpe_pkg::*;
(
    input  wire logic                     clk,
    input  wire chain_ctrl_t              ctrl,
    input  wire logic [BITS_PER_STEP-1:0] carry_in,
    output logic      [BITS_PER_STEP-1:0] carry_out,
    output logic      [CODE_WIDTH-1:0]    digit
);

    logic [CODE_WIDTH-1:0] digit_reg;
    logic [CODE_WIDTH-1:0] digit_next;
    logic [CODE_WIDTH-1:0] work;

    // Several add-3-and-shift steps per clock; step k takes carry_in[k] from
    // the lower neighbor and passes its top bit upward as carry_out[k].
    always_comb
    begin
        work      = digit_reg;
        carry_out = '0;
        for (int k = 0; k < BITS_PER_STEP; k++)
        begin
            if (work >= 4'd5)
            begin
                work = work + 4'd3;
            end
            carry_out[k] = work[CODE_WIDTH-1];
            work         = {work[CODE_WIDTH-2:0], carry_in[k]};
        end

        priority if (ctrl.load)
        begin
            digit_next = '0;
        end
        else if (ctrl.step)
        begin
            digit_next = work;
        end
        else
        begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;

endmodule

`default_nettype wire

/* rtl/core/dpe_bcd_chain.sv */
`default_nettype none

module dpe_bcd_chain
    import dpe_pkg::*;
(
    input  wire logic                 clk,
    input  wire chain_ctrl_t          ctrl,
    input  wire logic [BIN_WIDTH-1:0] value,
    output digit_vec_t                digits
);

    logic [BIN_WIDTH-1:0]     bin_reg;
    logic [BIN_WIDTH-1:0]     bin_next;
    logic [BITS_PER_STEP-1:0] carry [NUM_DIGITS];

    // Binary word shifts out most significant bits first into the lowest cell.
    always_comb
    begin
        priority if (ctrl.load)
        begin
            bin_next = value;
        end
        else if (ctrl.step)
        begin
            bin_next = bin_reg << BITS_PER_STEP;
        end
        else
        begin
            bin_next = bin_reg;
        end

        for (int k = 0; k < BITS_PER_STEP; k++)
        begin
            carry[0][k] = bin_reg[BIN_WIDTH-1-k];
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
    end

    // Row of digit cells, each feeding its carries to the next one up.
    for (genvar i = 0; i < NUM_DIGITS; i++)
    begin : g_cell
        if (i < NUM_DIGITS - 1)
        begin : g_mid
            dpe_digit_cell u_cell
            (
                .clk       (clk),
                .ctrl      (ctrl),
                .carry_in  (carry[i]),
                .carry_out (carry[i+1]),
                .digit     (digits[i])
            );
        end
        else
        begin : g_top
            // The row is wide enough that the top cell never carries out.
            dpe_digit_cell u_cell
            (
                .clk       (clk),
                .ctrl      (ctrl),
                .carry_in  (carry[i]),
                .carry_out (),
                .digit     (digits[i])
            );
        end
    end

endmodule

`default_nettype wire

/* rtl/core/dispenser_display_packet_encoder.sv */
// The first byte of a packet appears on the output after its request word has been
// accepted and has passed the multiply stage, the BCD conversion steps and the format and load step.
// Packets of 16 bytes go out one byte per accepted handshake; the byte output stage paces
// the packets, and the BCD rows convert the next request while a packet streams out.
// Reset (rst_n, asynchronous, active low) empties all stages and clears the
// unit price to 0.
`default_nettype none

module dispenser_display_packet_encoder
    import dpe_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [PRICE_WIDTH-1:0] cfg_wdata,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire in_word_t               in_word,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output out_word_t                   out_word
);

    // Configuration register.
    logic [PRICE_WIDTH-1:0] price_reg;
    logic [PRICE_WIDTH-1:0] price_next;

    // Multiply stage.
    logic                    m_valid_reg;
    logic                    m_valid_next;
    logic                    m_cmd_reg;
    logic                    m_cmd_next;
    logic [PRICE_WIDTH-1:0]  m_price_reg;
    logic [PRICE_WIDTH-1:0]  m_price_next;
    logic [VOLUME_WIDTH-1:0] m_vol_reg;
    logic [VOLUME_WIDTH-1:0] m_vol_next;
    logic [WIDE_WIDTH-1:0]   m_wide_reg;
    logic [WIDE_WIDTH-1:0]   m_wide_next;

    // Conversion stage.
    logic                 c_valid_reg;
    logic                 c_valid_next;
    logic                 c_cmd_reg;
    logic                 c_cmd_next;
    logic [CNT_WIDTH-1:0] c_cnt_reg;
    logic [CNT_WIDTH-1:0] c_cnt_next;
    logic                 c_done;

    // Byte output stage.
    logic                 o_valid_reg;
    logic                 o_valid_next;
    logic [IDX_WIDTH-1:0] o_idx_reg;
    logic [IDX_WIDTH-1:0] o_idx_next;
    code_vec_t            o_code_reg;
    code_vec_t            o_code_next;
    logic                 o_last;
    logic                 o_free;

    // Handshakes between stages.
    logic in_accept;
    logic out_accept;
    logic m_to_c;
    logic c_to_o;

    chain_ctrl_t           chain_ctrl;
    digit_vec_t            dig_wide;
    digit_vec_t            dig_vol;
    digit_vec_t            dig_price;
    logic [NUM_DIGITS-1:0] nz_wide;
    logic [NUM_DIGITS-1:0] nz_vol;
    logic [NUM_DIGITS-1:0] nz_price;
    code_vec_t             fmt_code;

    // Stage flow control.
    always_comb
    begin
        o_last     = (o_idx_reg == IDX_WIDTH'(PACKET_LEN - 1));
        out_accept = o_valid_reg && !out_stall;
        o_free     = !o_valid_reg || (out_accept && o_last);
        c_done     = c_valid_reg && (c_cnt_reg == CNT_WIDTH'(STEP_COUNT));
        c_to_o     = c_done && o_free;
        m_to_c     = m_valid_reg && (!c_valid_reg || c_to_o);
        in_stall   = m_valid_reg && !m_to_c;
        in_accept  = in_valid && !in_stall;
    end

    // Price register and multiply stage: the sale product volume * price is
    // formed here; its BCD digits above the third give floor(product / 1000).
    always_comb
    begin
        price_next   = cfg_we ? cfg_wdata : price_reg;
        m_valid_next = in_accept ? 1'b1 : (m_to_c ? 1'b0 : m_valid_reg);
        m_cmd_next   = m_cmd_reg;
        m_price_next = m_price_reg;
        m_vol_next   = m_vol_reg;
        m_wide_next  = m_wide_reg;
        if (in_accept)
        begin
            m_cmd_next   = in_word.command;
            m_price_next = price_reg;
            m_vol_next   = in_word.volume_milli;
            unique case (in_word.command)
                CMD_SALE:
                begin
                    m_wide_next = WIDE_WIDTH'(WIDE_WIDTH'(in_word.volume_milli)
                                              * WIDE_WIDTH'(price_reg));
                end
                CMD_TOTAL:
                begin
                    m_wide_next = in_word.totalizer_milli;
                end
                default:
                begin
                    m_wide_next = m_wide_reg;
                end
            endcase
        end
    end

    // Conversion sequencer: load the rows, then step them STEP_COUNT times.
    always_comb
    begin
        chain_ctrl.load = m_to_c;
        chain_ctrl.step = c_valid_reg && !c_done;
        c_valid_next    = m_to_c ? 1'b1 : (c_to_o ? 1'b0 : c_valid_reg);
        c_cmd_next      = m_to_c ? m_cmd_reg : c_cmd_reg;
        priority if (m_to_c)
        begin
            c_cnt_next = '0;
        end
        else if (chain_ctrl.step)
        begin
            c_cnt_next = c_cnt_reg + CNT_WIDTH'(1);
        end
        else
        begin
            c_cnt_next = c_cnt_reg;
        end
    end

    // Three conversion rows: product or counter, volume, price.
    dpe_bcd_chain u_chain_wide
    (
        .clk    (clk),
        .ctrl   (chain_ctrl),
        .value  (BIN_WIDTH'(m_wide_reg)),
        .digits (dig_wide)
    );

    dpe_bcd_chain u_chain_vol
    (
        .clk    (clk),
        .ctrl   (chain_ctrl),
        .value  (BIN_WIDTH'(m_vol_reg)),
        .digits (dig_vol)
    );

    dpe_bcd_chain u_chain_price
    (
        .clk    (clk),
        .ctrl   (chain_ctrl),
        .value  (BIN_WIDTH'(m_price_reg)),
        .digits (dig_price)
    );

    // Packet formatting with leading-zero blanking.
    always_comb
    begin
        nz_wide  = suffix_nonzero(dig_wide);
        nz_vol   = suffix_nonzero(dig_vol);
        nz_price = suffix_nonzero(dig_price);
        fmt_code = '0;
        for (int i = 0; i < 4; i++)
        begin
            fmt_code[i] = disp_code(dig_price[i], nz_price[i], i == 0);
        end
        unique case (c_cmd_reg)
            CMD_SALE:
            begin
                for (int i = 0; i < 6; i++)
                begin
                    fmt_code[4+i]  = disp_code(dig_wide[AMOUNT_SHIFT+i],
                                               nz_wide[AMOUNT_SHIFT+i], i == 0);
                    fmt_code[10+i] = disp_code(dig_vol[i], nz_vol[i], i == 0);
                end
            end
            CMD_TOTAL:
            begin
                for (int i = 0; i < 6; i++)
                begin
                    fmt_code[10+i] = disp_code(dig_wide[i], nz_wide[i], 1'b0);
                end
                for (int i = 0; i < 4; i++)
                begin
                    fmt_code[4+i] = disp_code(dig_wide[6+i], nz_wide[6+i], 1'b0);
                end
                fmt_code[8] = L_CODE;
                fmt_code[9] = L_CODE;
            end
            default:
            begin
                fmt_code = '0;
            end
        endcase
    end

    // Output shift stage: one word per accepted handshake, code 0 goes first.
    always_comb
    begin
        o_valid_next = o_valid_reg;
        o_idx_next   = o_idx_reg;
        o_code_next  = o_code_reg;
        priority if (c_to_o)
        begin
            o_valid_next = 1'b1;
            o_idx_next   = '0;
            o_code_next  = fmt_code;
        end
        else if (out_accept)
        begin
            o_valid_next = !o_last;
            o_idx_next   = o_idx_reg + IDX_WIDTH'(1);
            o_code_next  = {CODE_WIDTH'(0), o_code_reg[PACKET_LEN-1:1]};
        end
        else
        begin
            o_valid_next = o_valid_reg;
        end
    end

    assign out_valid               = o_valid_reg;
    assign out_word.packet_byte    = {o_code_reg[0], o_idx_reg};
    assign out_word.last_of_packet = o_last;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            price_reg   <= '0;
            m_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            c_cnt_reg   <= '0;
            o_valid_reg <= 1'b0;
            o_idx_reg   <= '0;
        end
        else
        begin
            price_reg   <= price_next;
            m_valid_reg <= m_valid_next;
            c_valid_reg <= c_valid_next;
            c_cnt_reg   <= c_cnt_next;
            o_valid_reg <= o_valid_next;
            o_idx_reg   <= o_idx_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        m_cmd_reg   <= m_cmd_next;
        m_price_reg <= m_price_next;
        m_vol_reg   <= m_vol_next;
        m_wide_reg  <= m_wide_next;
        c_cmd_reg   <= c_cmd_next;
        o_code_reg  <= o_code_next;
    end

endmodule

`default_nettype wire

/* rtl/core/dpe_checker.sv */
`default_nettype none

module dpe_checker
    import dpe_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_word_t out_word
);

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("output word changed while stalled");

    // Within a packet the byte positions count up with no gap.
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_word.last_of_packet |=>
            out_valid &&
            (out_word.packet_byte[IDX_WIDTH-1:0] ==
             $past(out_word.packet_byte[IDX_WIDTH-1:0]) + IDX_WIDTH'(1)))
        else $error("packet byte position skipped");

    // The end flag marks exactly the sixteenth byte.
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.last_of_packet ==
                       (out_word.packet_byte[IDX_WIDTH-1:0] == IDX_WIDTH'(PACKET_LEN - 1))))
        else $error("end of packet flag on the wrong byte");

    // Only digits, 'L' and blank are ever shown.
    a_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.packet_byte[BYTE_WIDTH-1:IDX_WIDTH] <= L_CODE ||
                       out_word.packet_byte[BYTE_WIDTH-1:IDX_WIDTH] == BLANK_CODE))
        else $error("illegal display code");

endmodule

bind dispenser_display_packet_encoder dpe_checker u_dpe_checker (.*);

`default_nettype wire
